// ===== hdl/rde_pkg.sv =====
package rde_pkg;

    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 5;
    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = 4;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_SYMBOLS = 16;
    localparam int MAX_DIGITS  = 32;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int BITCNT_W    = $clog2(VALUE_W);
    localparam int REM_W       = DIGIT_W + 1;

    localparam logic [SYM_W-1:0]   ASCII_ZERO = 8'h30;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
    localparam logic [CFG_W-1:0]   SYM_LO_RESET  = 64'd3978425819141910832;
    localparam logic [CFG_W-1:0]   SYM_HI_RESET  = 64'd7378413942531504440;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI  = 2'd2;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] digit;
    } div_result_t;

    function automatic logic [SYM_W-1:0] symbol_of(
        input logic [DIGIT_W-1:0] d,
        input logic [CFG_W-1:0]   lo,
        input logic [CFG_W-1:0]   hi
    );
        logic [CFG_W-1:0] bank;
        bank = d[DIGIT_W-1] ? hi : lo;
        return bank[SYM_W*d[DIGIT_W-2:0] +: SYM_W];
    endfunction

endpackage

// ===== hdl/radix_digit_emitter.sv =====
// Converts each 32-bit value to its digits in the configured radix (2 to 16, larger
// values act as 16) and sends them most significant first, one symbol byte per
// transaction, with m_last on the final one. A zero value, or a radix below two,
// gives the single byte 0x30. Digits come from a bit-serial restoring divider that
// retires one quotient bit per cycle, one full division per digit. The next value
// is taken once the last symbol has left the stack, while that symbol may still
// wait in the output register. Registers: index 0 radix, 1 symbols for digits 0-7,
// 2 symbols for digits 8-15, lowest byte first; write them only while idle.
// cfg_ready is always high.
module radix_digit_emitter
    import rde_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [VALUE_W-1:0]   s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SYM_W-1:0]     m_symbol,
    output logic                 m_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_ZERO
    } state_t;

    state_t             state_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic [CFG_W-1:0]   sym_lo_reg;
    logic [CFG_W-1:0]   sym_hi_reg;
    logic [RADIX_W-1:0] work_radix_reg;
    logic               m_valid_reg;
    logic [SYM_W-1:0]   m_symbol_reg;
    logic               m_last_reg;

    logic [RADIX_W-1:0] radix_sat;
    logic               s_take;
    logic               out_free;
    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    logic [RADIX_W-1:0] div_divisor;
    div_result_t        div_res;
    logic               push;
    logic               pop;
    logic [CNT_W-1:0]   count;
    logic [DIGIT_W-1:0] top_digit;
    logic               div_more;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_take    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign radix_sat = (radix_reg > RADIX_W'(MAX_SYMBOLS)) ? RADIX_W'(MAX_SYMBOLS)
                                                           : radix_reg;

    assign push     = (state_reg == ST_DIV) && div_res.done;
    assign div_more = (div_res.quotient != '0) && (count != CNT_W'(MAX_DIGITS - 1));
    assign pop      = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = s_value;
        div_divisor  = radix_sat;
        if (state_reg == ST_IDLE) begin
            div_start = s_take && (s_value != '0) && (radix_sat >= RADIX_W'(2));
        end else if (push && div_more) begin
            div_start    = 1'b1;
            div_dividend = div_res.quotient;
            div_divisor  = work_radix_reg;
        end
    end

    rde_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    rde_digit_stack u_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_digit (div_res.digit),
        .pop        (pop),
        .count      (count),
        .top_digit  (top_digit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg  <= RADIX_RESET;
            sym_lo_reg <= SYM_LO_RESET;
            sym_hi_reg <= SYM_HI_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RADIX:  radix_reg  <= cfg_data[RADIX_W-1:0];
                CFG_SYM_LO: sym_lo_reg <= cfg_data;
                CFG_SYM_HI: sym_hi_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= (m_valid_reg && !m_ready)
                        || (((state_reg == ST_EMIT) || (state_reg == ST_ZERO)) && out_free);
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_take) begin
                        state_reg <= div_start ? ST_DIV : ST_ZERO;
                    end
                end
                ST_DIV: begin
                    if (push && !div_more) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free && count == CNT_W'(1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ZERO: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
        if (s_take) begin
            work_radix_reg <= radix_sat;
        end
        if (pop) begin
            m_symbol_reg <= symbol_of(top_digit, sym_lo_reg, sym_hi_reg);
            m_last_reg   <= (count == CNT_W'(1));
        end else if (state_reg == ST_ZERO && out_free) begin
            m_symbol_reg <= ASCII_ZERO;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== hdl/rde_divider.sv =====
module rde_divider
    import rde_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [RADIX_W-1:0] divisor,
    output div_result_t        result
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [BITCNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  quo_reg, quo_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [RADIX_W-1:0]  div_reg, div_next;
    logic [REM_W-1:0]    trial;
    logic [REM_W-1:0]    diff;
    logic                ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[VALUE_W-1]};
    assign ge    = trial >= div_reg;
    assign diff  = trial - div_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_W-2:0], ge};
            rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BITCNT_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;
    assign result.digit    = rem_reg;

endmodule

// ===== hdl/rde_digit_stack.sv =====
module rde_digit_stack
    import rde_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [DIGIT_W-1:0] push_digit,
    input  logic               pop,
    output logic [CNT_W-1:0]   count,
    output logic [DIGIT_W-1:0] top_digit
);

    logic [DIGIT_W-1:0] buf_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0] top_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   top_pos;
    logic [CNT_W-1:0]   below_pos;

    assign top_pos   = count_reg - 1'b1;
    assign below_pos = count_reg - 2'd2;

    always_comb begin
        count_next = count_reg;
        if (push) begin
            count_next = count_reg + 1'b1;
        end else if (pop) begin
            count_next = top_pos;
        end
    end

    // top_reg holds the newest entry; a pop fetches the one beneath it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        if (push) begin
            buf_reg[count_reg[IDX_W-1:0]] <= push_digit;
            top_reg                       <= push_digit;
        end else if (pop) begin
            top_reg <= buf_reg[below_pos[IDX_W-1:0]];
        end
    end

    assign count     = count_reg;
    assign top_digit = top_reg;

endmodule

// ===== verif/tb_radix_digit_emitter.sv =====
`timescale 1ns / 1ps

module tb_radix_digit_emitter;
    import rde_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } symbol_t;

    typedef enum int {SENDER_SLOW, RECEIVER_SLOW, NO_IDLE} idle_profile_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_ROUNDS   = 20;
    localparam int ITEMS_PER_ROUND = 18;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [VALUE_W-1:0]   s_value   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [SYM_W-1:0]     m_symbol;
    logic                 m_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic [RADIX_W-1:0] radix_reg  = RADIX_RESET;
    logic [CFG_W-1:0]   alpha_lo   = SYM_LO_RESET;
    logic [CFG_W-1:0]   alpha_hi   = SYM_HI_RESET;
    symbol_t            expected_symbols[$];
    symbol_t            want;
    int                 mismatches = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;

    radix_digit_emitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_symbol  (m_symbol),
        .m_last    (m_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [SYM_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [2*CFG_W-1:0] alphabet;
        alphabet = {alpha_hi, alpha_lo};
        return alphabet[SYM_W*d +: SYM_W];
    endfunction

    function automatic void queue_digits(input logic [VALUE_W-1:0] v);
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        logic [VALUE_W-1:0] rest;
        int unsigned        base;
        int                 n;
        base = (radix_reg > MAX_SYMBOLS) ? MAX_SYMBOLS : radix_reg;
        if (v == 0 || base < 2) begin
            expected_symbols.push_back('{ASCII_ZERO, 1'b1});
            return;
        end
        rest = v;
        n = 0;
        while (rest != 0 && n < MAX_DIGITS) begin
            digits[n] = DIGIT_W'(rest % base);
            rest = rest / base;
            n++;
        end
        for (int i = n - 1; i >= 0; i--)
            expected_symbols.push_back('{glyph(digits[i]), i == 0});
    endfunction

    task automatic set_idle(input idle_profile_t p);
        case (p)
            SENDER_SLOW: begin
                send_idle_pct = 36;
                recv_idle_pct = 67;
            end
            RECEIVER_SLOW: begin
                send_idle_pct = 67;
                recv_idle_pct = 36;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        queue_digits(v);
    endtask

    // all symbols out, then let the block settle before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_symbols.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIX:  radix_reg = data[RADIX_W-1:0];
            CFG_SYM_LO: alpha_lo  = data;
            CFG_SYM_HI: alpha_hi  = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_symbols.size() == 0) begin
                $error("unexpected transaction: symbol %h last %b", m_symbol, m_last);
                mismatches++;
            end else begin
                want = expected_symbols.pop_front();
                if (m_symbol !== want.symbol) begin
                    $error("symbol: expected %h, actual %h", want.symbol, m_symbol);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_reset_alphabet();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
    endtask

    task automatic test_binary_extremes();
        drain();
        write_register(CFG_RADIX, 64'd2);
        write_register(CFG_SYM_LO, 64'h0000_0000_0000_FF00);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);
    endtask

    task automatic test_hex_alphabet_extremes();
        drain();
        write_register(CFG_RADIX, 64'd16);
        write_register(CFG_SYM_LO, '0);
        write_register(CFG_SYM_HI, '1);
        send_value(32'hFEDC_BA98);
        send_value(32'h7654_3210);
        send_value(32'd0);
    endtask

    // radix 0 and 1 always give ASCII zero
    task automatic test_degenerate_radix();
        drain();
        write_register(CFG_RADIX, 64'd0);
        send_value(32'hFFFF_FFFF);
        drain();
        write_register(CFG_RADIX, 64'd1);
        send_value(32'h1234_5678);
    endtask

    task automatic test_radix_saturation();
        drain();
        write_register(CFG_SYM_LO, 64'h3736_3534_3332_3130);
        write_register(CFG_SYM_HI, 64'h4645_4443_4241_3938);
        write_register(CFG_RADIX, 64'd31);
        send_value(32'hDEAD_BEEF);
        drain();
        write_register(CFG_RADIX, 64'd17);
        send_value(32'hFFFF_FFFF);
    endtask

    task automatic test_unmapped_register();
        drain();
        write_register(CFG_UNUSED, '1);
        send_value(32'hCAFE_F00D);
    endtask

    task automatic test_random_traffic();
        logic [RADIX_W-1:0] r;
        logic [CFG_W-1:0]   data;
        logic [VALUE_W-1:0] v;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            drain();
            set_idle(idle_profile_t'(round * 3 / RANDOM_ROUNDS));
            case ($urandom_range(0, 9))
                0:       r = RADIX_W'($urandom_range(0, 1));
                1:       r = RADIX_W'($urandom_range(17, 31));
                2, 3:    r = RADIX_W'($urandom_range(2, 7));
                default: r = RADIX_W'($urandom_range(8, 16));
            endcase
            data = {$urandom, $urandom};
            data[RADIX_W-1:0] = r;
            write_register(CFG_RADIX, data);
            if ($urandom_range(0, 1))
                write_register(CFG_SYM_LO, {$urandom, $urandom});
            if ($urandom_range(0, 1))
                write_register(CFG_SYM_HI, {$urandom, $urandom});
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_UNUSED, {$urandom, $urandom});
            for (int k = 0; k < ITEMS_PER_ROUND; k++) begin
                case ($urandom_range(0, 9))
                    0:       v = '0;
                    1:       v = '1;
                    2, 3:    v = $urandom_range(0, 255);
                    4:       v = 32'd1 << $urandom_range(0, VALUE_W - 1);
                    default: v = $urandom;
                endcase
                send_value(v);
            end
        end
    endtask

    initial begin
        set_idle(SENDER_SLOW);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_alphabet();
        test_binary_extremes();
        test_hex_alphabet_extremes();
        test_degenerate_radix();
        test_radix_saturation();
        test_unmapped_register();
        test_random_traffic();

        drain();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rde_pkg.sv
hdl/rde_divider.sv
hdl/rde_digit_stack.sv
hdl/radix_digit_emitter.sv
verif/tb_radix_digit_emitter.sv
